### rtl/sorted_priority_queue_top_macros.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTH
`define SPQ_ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("spq assertion failed");
`else
`define SPQ_ASSERT_IMPLY(label, clk, rst, a, c)
`define SPQ_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### rtl/spq_pkg.sv
// shared types and codes for the sorted priority queue
package spq_pkg;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

### rtl/spq_cell.sv
// one storage cell of the sorted shift chain
module spq_cell #(
   parameter int PRIORITY_WIDTH = 16,
   parameter int TAG_WIDTH      = 32
) (
   input  logic                      clock,
   input  spq_pkg::cell_ctrl_type    ctrl,
   input  logic                      occupied,
   input  logic [PRIORITY_WIDTH-1:0] new_priority,
   input  logic [TAG_WIDTH-1:0]      new_tag,
   input  logic                      prev_keep,
   input  logic [PRIORITY_WIDTH-1:0] prev_priority,
   input  logic [TAG_WIDTH-1:0]      prev_tag,
   input  logic [PRIORITY_WIDTH-1:0] next_priority,
   input  logic [TAG_WIDTH-1:0]      next_tag,
   output logic                      keep,
   output logic [PRIORITY_WIDTH-1:0] cell_priority,
   output logic [TAG_WIDTH-1:0]      cell_tag
);
   import spq_pkg::*;

   logic [PRIORITY_WIDTH-1:0] priority_ff, priority_in;
   logic [TAG_WIDTH-1:0]      tag_ff, tag_in;

   assign keep = occupied && (priority_ff <= new_priority);

   always_comb begin
      priority_in = priority_ff;
      tag_in      = tag_ff;
      if (ctrl.insert) begin
         if (!keep) begin
            if (prev_keep) begin
               priority_in = new_priority;
               tag_in      = new_tag;
            end else begin
               priority_in = prev_priority;
               tag_in      = prev_tag;
            end
         end
      end else if (ctrl.remove) begin
         priority_in = next_priority;
         tag_in      = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      tag_ff      <= tag_in;
   end

   assign cell_priority = priority_ff;
   assign cell_tag      = tag_ff;

endmodule

### rtl/sorted_priority_queue_top.sv
// sorted priority queue top level: chain of cells, count and result register
//
// Usage: drive req_kind, req_priority_req and req_tag with start high; the
// request is taken at a rising edge where start is high and busy is low.
// req_kind low inserts an entry behind all held entries of lower or equal
// priority; high removes the entry with the lowest priority value.
// Every request gives one result in the following cycle: rsp_done is high for
// exactly one cycle with rsp_out_valid, rsp_out_priority, rsp_out_tag,
// rsp_status and rsp_occupancy. An insert into a full queue returns the
// full status, a remove from an empty queue the empty status.
// Throughput: one request per cycle, back to back, while busy is low; every
// cell of the chain compares against the new priority and shifts to its
// neighbor in the same cycle.
// Reset (synchronous, active high) empties the queue; busy is high during
// reset. The receiver cannot stall, results must be taken when shown.
module sorted_priority_queue_top #(
   parameter int DEPTH          = 8,
   parameter int PRIORITY_WIDTH = 16,
   parameter int TAG_WIDTH      = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [PRIORITY_WIDTH-1:0]     req_priority_req,
   input  logic [TAG_WIDTH-1:0]          req_tag,
   output logic                          rsp_done,
   output logic                          rsp_out_valid,
   output logic [PRIORITY_WIDTH-1:0]     rsp_out_priority,
   output logic [TAG_WIDTH-1:0]          rsp_out_tag,
   output spq_pkg::status_type           rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_occupancy
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]             count_ff, count_in;
   logic                      done_ff, done_in;
   logic                      out_valid_ff, out_valid_in;
   logic [PRIORITY_WIDTH-1:0] out_priority_ff, out_priority_in;
   logic [TAG_WIDTH-1:0]      out_tag_ff, out_tag_in;
   status_type                status_ff, status_in;

   logic          accept, full, empty;
   cell_ctrl_type ctrl;

   logic [DEPTH-1:0]          keep;
   logic [DEPTH-1:0]          occupied;
   logic [PRIORITY_WIDTH-1:0] cell_priority [DEPTH];
   logic [TAG_WIDTH-1:0]      cell_tag [DEPTH];

   assign busy   = reset;
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   assign ctrl.insert = accept && (req_kind == KIND_INSERT) && !full;
   assign ctrl.remove = accept && (req_kind == KIND_REMOVE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      prev_keep;
      logic [PRIORITY_WIDTH-1:0] prev_priority, next_priority;
      logic [TAG_WIDTH-1:0]      prev_tag, next_tag;

      assign occupied[i] = (CW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign prev_keep     = 1'b1;
         assign prev_priority = req_priority_req;
         assign prev_tag      = req_tag;
      end else begin : g_mid
         assign prev_keep     = keep[i-1];
         assign prev_priority = cell_priority[i-1];
         assign prev_tag      = cell_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_priority = cell_priority[i];
         assign next_tag      = cell_tag[i];
      end else begin : g_inner
         assign next_priority = cell_priority[i+1];
         assign next_tag      = cell_tag[i+1];
      end

      spq_cell #(
         .PRIORITY_WIDTH (PRIORITY_WIDTH),
         .TAG_WIDTH      (TAG_WIDTH)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .occupied      (occupied[i]),
         .new_priority  (req_priority_req),
         .new_tag       (req_tag),
         .prev_keep     (prev_keep),
         .prev_priority (prev_priority),
         .prev_tag      (prev_tag),
         .next_priority (next_priority),
         .next_tag      (next_tag),
         .keep          (keep[i]),
         .cell_priority (cell_priority[i]),
         .cell_tag      (cell_tag[i])
      );
   end

   always_comb begin
      count_in        = count_ff;
      done_in         = accept;
      out_valid_in    = 1'b0;
      out_priority_in = '0;
      out_tag_in      = '0;
      status_in       = STATUS_OK;
      if (accept) begin
         if (req_kind == KIND_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in        = count_ff - CW'(1);
               out_valid_in    = 1'b1;
               out_priority_in = cell_priority[0];
               out_tag_in      = cell_tag[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff    <= out_valid_in;
      out_priority_ff <= out_priority_in;
      out_tag_ff      <= out_tag_in;
      status_ff       <= status_in;
   end

   assign rsp_done         = done_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_priority = out_priority_ff;
   assign rsp_out_tag      = out_tag_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = count_ff;

`include "sorted_priority_queue_top_macros.svh"

   `SPQ_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `SPQ_ASSERT_NEXT(a_empty_remove, clock, reset, accept && req_kind == KIND_REMOVE && empty,
      rsp_done && rsp_status == STATUS_EMPTY && !rsp_out_valid && count_ff == '0)
   `SPQ_ASSERT_NEXT(a_full_insert, clock, reset, accept && req_kind == KIND_INSERT && full,
      rsp_done && rsp_status == STATUS_FULL && $stable(count_ff))
   `SPQ_ASSERT_NEXT(a_insert_count, clock, reset, ctrl.insert,
      count_ff == $past(count_ff) + CW'(1) && rsp_status == STATUS_OK)

endmodule

### tb/sv/spq_checker.sv
`timescale 1ns / 100ps
// checker for the sorted priority queue: tracks held entries, predicts and compares results
module spq_checker #(
   parameter int DEPTH          = 8,
   parameter int PRIORITY_WIDTH = 16,
   parameter int TAG_WIDTH      = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_kind,
   input  logic [PRIORITY_WIDTH-1:0]     req_priority_req,
   input  logic [TAG_WIDTH-1:0]          req_tag,
   input  logic                          rsp_done,
   input  logic                          rsp_out_valid,
   input  logic [PRIORITY_WIDTH-1:0]     rsp_out_priority,
   input  logic [TAG_WIDTH-1:0]          rsp_out_tag,
   input  spq_pkg::status_type           rsp_status,
   input  logic [$clog2(DEPTH+1)-1:0]    rsp_occupancy,
   output int                            fail_count,
   output int                            pending_count
);
   import spq_pkg::*;

   localparam int OCC_WIDTH = $clog2(DEPTH + 1);

   typedef struct {
      logic                      removed;
      logic [PRIORITY_WIDTH-1:0] priority_out;
      logic [TAG_WIDTH-1:0]      tag_out;
      status_type                status;
      logic [OCC_WIDTH-1:0]      occupancy;
   } queue_result_type;

   logic [PRIORITY_WIDTH-1:0] held_priority [DEPTH];
   logic [TAG_WIDTH-1:0]      held_tag [DEPTH];
   int                        held_count = 0;
   queue_result_type          awaited_results [$];
   int                        mismatches = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic queue_result_type apply_request(input logic kind,
                                                      input logic [PRIORITY_WIDTH-1:0] pri,
                                                      input logic [TAG_WIDTH-1:0] tag);
      queue_result_type r;
      int               pos;
      int               i;
      r.removed      = 1'b0;
      r.priority_out = '0;
      r.tag_out      = '0;
      r.status       = STATUS_OK;
      if (kind == KIND_INSERT) begin
         if (held_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < held_count && held_priority[pos] <= pri) pos++;
            for (i = held_count; i > pos; i--) begin
               held_priority[i] = held_priority[i-1];
               held_tag[i]      = held_tag[i-1];
            end
            held_priority[pos] = pri;
            held_tag[pos]      = tag;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.removed      = 1'b1;
            r.priority_out = held_priority[0];
            r.tag_out      = held_tag[0];
            for (i = 0; i + 1 < held_count; i++) begin
               held_priority[i] = held_priority[i+1];
               held_tag[i]      = held_tag[i+1];
            end
            held_count--;
         end
      end
      r.occupancy = OCC_WIDTH'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_done) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result valid=%0b pri=%h tag=%h status=%0d occ=%0d",
                           $realtime, rsp_out_valid, rsp_out_priority, rsp_out_tag,
                           rsp_status, rsp_occupancy);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_out_valid !== want.removed || rsp_out_priority !== want.priority_out ||
                   rsp_out_tag !== want.tag_out || rsp_status !== want.status ||
                   rsp_occupancy !== want.occupancy) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch expected valid=%0b pri=%h tag=%h status=%0d occ=%0d",
                              $realtime, want.removed, want.priority_out, want.tag_out,
                              want.status, want.occupancy);
                     $display("%0t:          actual   valid=%0b pri=%h tag=%h status=%0d occ=%0d",
                              $realtime, rsp_out_valid, rsp_out_priority, rsp_out_tag,
                              rsp_status, rsp_occupancy);
                  end
               end
            end
         end
         if (start && !busy)
            awaited_results.push_back(apply_request(req_kind, req_priority_req, req_tag));
      end
      fail_count    <= mismatches;
      pending_count <= awaited_results.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench top for the sorted priority queue: clock, reset, request stimulus and verdict
module tb;
   import spq_pkg::*;

   localparam int DEPTH          = 8;
   localparam int PRIORITY_WIDTH = 16;
   localparam int TAG_WIDTH      = 32;
   localparam int OCC_WIDTH      = $clog2(DEPTH + 1);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 13;
   localparam int PHASE_LENGTH   = 50;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      start            = 1'b0;
   logic                      req_kind         = KIND_INSERT;
   logic [PRIORITY_WIDTH-1:0] req_priority_req = '0;
   logic [TAG_WIDTH-1:0]      req_tag          = '0;
   logic                      busy;
   logic                      rsp_done;
   logic                      rsp_out_valid;
   logic [PRIORITY_WIDTH-1:0] rsp_out_priority;
   logic [TAG_WIDTH-1:0]      rsp_out_tag;
   status_type                rsp_status;
   logic [OCC_WIDTH-1:0]      rsp_occupancy;
   int                        fail_count;
   int                        pending_count;
   int                        quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_priority_queue_top #(
      .DEPTH(DEPTH), .PRIORITY_WIDTH(PRIORITY_WIDTH), .TAG_WIDTH(TAG_WIDTH)
   ) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_priority_req(req_priority_req), .req_tag(req_tag),
      .rsp_done(rsp_done), .rsp_out_valid(rsp_out_valid),
      .rsp_out_priority(rsp_out_priority), .rsp_out_tag(rsp_out_tag),
      .rsp_status(rsp_status), .rsp_occupancy(rsp_occupancy)
   );

   spq_checker #(
      .DEPTH(DEPTH), .PRIORITY_WIDTH(PRIORITY_WIDTH), .TAG_WIDTH(TAG_WIDTH)
   ) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_priority_req(req_priority_req), .req_tag(req_tag),
      .rsp_done(rsp_done), .rsp_out_valid(rsp_out_valid),
      .rsp_out_priority(rsp_out_priority), .rsp_out_tag(rsp_out_tag),
      .rsp_status(rsp_status), .rsp_occupancy(rsp_occupancy),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_done) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   task automatic send_request(input logic kind, input logic [PRIORITY_WIDTH-1:0] pri,
                               input logic [TAG_WIDTH-1:0] tag);
      start            <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= pri;
      req_tag          <= tag;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int pick_gap(input bit idling);
      int roll;
      roll = $urandom_range(99);
      if (!idling || roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   initial begin
      int                        insert_share;
      bit                        idling;
      bit                        tie_heavy;
      logic                      kind;
      logic [PRIORITY_WIDTH-1:0] pri;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty remove, extremes, ties, fill, full insert, drain
      send_request(KIND_REMOVE, '1, '1);
      send_request(KIND_INSERT, '0, '0);
      send_request(KIND_INSERT, '1, '1);
      send_request(KIND_INSERT, 16'h8000, 32'h0000_0001);
      hold_off(1);
      send_request(KIND_INSERT, 16'h8000, 32'h0000_0002);
      send_request(KIND_INSERT, 16'h8000, 32'h0000_0003);
      hold_off(3);
      send_request(KIND_INSERT, '0, 32'h0000_0005);
      send_request(KIND_INSERT, 16'h7fff, 32'ha5a5_a5a5);
      send_request(KIND_INSERT, 16'h0001, 32'h5a5a_5a5a);
      send_request(KIND_INSERT, 16'h0003, 32'hffff_0000);
      for (int i = 0; i < DEPTH; i++) begin
         send_request(KIND_REMOVE, PRIORITY_WIDTH'($urandom), $urandom);
         hold_off(i % 3);
      end
      send_request(KIND_REMOVE, '0, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         insert_share = (phase % 2 == 0) ? 75 : 30;
         idling       = ($urandom_range(3) != 0);
         tie_heavy    = $urandom_range(1);
         for (int n = 0; n < PHASE_LENGTH; n++) begin
            kind = ($urandom_range(99) < insert_share) ? KIND_INSERT : KIND_REMOVE;
            if (tie_heavy) pri = PRIORITY_WIDTH'($urandom_range(7));
            else           pri = PRIORITY_WIDTH'($urandom);
            send_request(kind, pri, $urandom);
            hold_off(pick_gap(idling));
         end
      end

      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
tb/sv/spq_checker.sv
tb/sv/tb.sv
